// ===== design/crse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crse_pkg
// Shared types and constants for the Catmull-Rom spline evaluator.
// ----------------------------------------------------------------------------
package crse_pkg;

    localparam int KNOT_W     = 32;  // knot and result width
    localparam int IDX_W      = 5;   // knot_index field width
    localparam int POS_W      = 17;  // 1.16 position field width
    localparam int CNT_W      = 6;   // knot_count register width
    localparam int FRAC_SHIFT = 16;  // fixed-point fraction bits
    localparam int T_W        = 23;  // position * (n - 3)
    localparam int SPAN_W     = 7;   // integer part of t
    localparam int PROD_W     = KNOT_W + T_W + 1;

    // Stream word layout, lowest bit first
    localparam int IDX_LSB  = 0;
    localparam int VAL_LSB  = IDX_LSB + IDX_W;
    localparam int POS_LSB  = VAL_LSB + KNOT_W;
    localparam int S_DATA_W = 56;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_KNOT_COUNT = 1'b0;  // word address of knot_count
    localparam logic [CNT_W-1:0] KNOT_COUNT_RST = CNT_W'(4);

    // Item kinds carried on tuser
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    // Horner steps: which constant term follows each product
    localparam logic [1:0] STEP_B   = 2'd0;
    localparam logic [1:0] STEP_C   = 2'd1;
    localparam logic [1:0] STEP_END = 2'd2;

    // Sequencer controls for the Horner datapath
    typedef struct packed {
        logic       cap_en;   // capture memory read data into a knot register
        logic [1:0] cap_sel;  // which knot register (0..2)
        logic       prep;     // form first sum and the constant terms
        logic       mul;      // register accumulator * fraction
        logic       add;      // fold product back with the step's term
        logic [1:0] step;     // Horner step
    } crse_hctl_t;

    // Arithmetic halving
    function automatic logic [KNOT_W-1:0] half(input logic [KNOT_W-1:0] v);
        half = {v[KNOT_W-1], v[KNOT_W-1:1]};
    endfunction

endpackage : crse_pkg
`default_nettype wire

// ===== design/crse_knot_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crse_knot_mem
// Knot table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module crse_knot_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [crse_pkg::KNOT_W-1:0] wr_data,
    input  wire logic                       re,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic      [crse_pkg::KNOT_W-1:0] rd_data
);
    import crse_pkg::*;

    logic [KNOT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : crse_knot_mem
`default_nettype wire

// ===== design/crse_horner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crse_horner
// Horner datapath: knot capture, constant terms, shared multiplier.
// ----------------------------------------------------------------------------
module crse_horner (
    input  wire logic                        clk,
    input  wire crse_pkg::crse_hctl_t        ctl,
    input  wire logic [crse_pkg::T_W-1:0]    c1,
    input  wire logic [crse_pkg::KNOT_W-1:0] rd_data,
    output logic      [crse_pkg::KNOT_W-1:0] acc
);
    import crse_pkg::*;

    logic [KNOT_W-1:0] k0_reg, k1_reg, k2_reg;
    logic [KNOT_W-1:0] acc_reg, termb_reg, termc_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [KNOT_W-1:0] k3;
    logic [KNOT_W-1:0] sum_a, term_b, term_c;
    logic [PROD_W-1:0] prod_next;
    logic [KNOT_W-1:0] frac;
    logic [KNOT_W-1:0] addend;

    always_comb
    begin
        // last knot arrives straight from the memory in the prep cycle
        k3     = rd_data;
        sum_a  = half(k1_reg) - half(k2_reg) - k2_reg + k1_reg + half(k3)
               + half(~k0_reg);
        term_b = k0_reg + {k2_reg[KNOT_W-2:0], 1'b0} - {k1_reg[KNOT_W-2:0], 1'b0}
               - half(k1_reg) - half(k3);
        term_c = half(k2_reg) + half(~k0_reg);

        // signed accumulator times non-negative fraction
        prod_next = PROD_W'($signed(PROD_W'($signed(acc_reg)))
                          * $signed(PROD_W'({1'b0, c1})));
        frac      = prod_reg[FRAC_SHIFT +: KNOT_W];

        case (ctl.step)
            STEP_B:  addend = termb_reg;
            STEP_C:  addend = termc_reg;
            default: addend = k1_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap_en)
        begin
            case (ctl.cap_sel)
                2'd0:    k0_reg <= rd_data;
                2'd1:    k1_reg <= rd_data;
                default: k2_reg <= rd_data;
            endcase
        end
        if (ctl.prep)
        begin
            acc_reg   <= sum_a;
            termb_reg <= term_b;
            termc_reg <= term_c;
        end
        if (ctl.mul)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.add)
        begin
            acc_reg <= frac + addend;
        end
    end

    assign acc = acc_reg;

endmodule : crse_horner
`default_nettype wire

// ===== design/catmull_rom_spline_eval.sv =====
`default_nettype none
// Knot write: taken whenever the sequencer is idle; no result.
// Evaluate: no new item is taken until the result word is in the output register,
// after four reads through the single knot memory read port and three multiply/add
// rounds on the shared multiplier; a still-full output register holds the sequencer.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, async) idles the sequencer, clears the output, sets knot_count to 4.
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval
// Uniform Catmull-Rom spline evaluator in 16.16 fixed point over a knot
// table held in a synchronous memory; knots are undefined until written.
// ----------------------------------------------------------------------------
module catmull_rom_spline_eval #(
    parameter int MAX_KNOTS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // knot_index[4:0], knot_value[36:5], position[53:37], zero pad [55:54]
    input  wire logic [crse_pkg::S_DATA_W-1:0]     s_tdata,
    // kind[0]
    input  wire logic                              s_tuser,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // value[31:0]
    output logic      [crse_pkg::KNOT_W-1:0]       m_tdata,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [crse_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [crse_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [crse_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import crse_pkg::*;

    localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PREP,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg,  state_next;
    logic [1:0]          rd_cnt_reg, rd_cnt_next;
    logic [1:0]          step_reg,   step_next;
    logic [SPAN_W-1:0]   span_reg,   span_next;
    logic [T_W-1:0]      c1_reg,     c1_next;
    logic                out_valid_reg, out_valid_next;
    logic [KNOT_W-1:0]   out_data_reg,  out_data_next;
    logic [CNT_W-1:0]    knot_count_reg;

    // ------------------------------------------------------------------
    // Input word fields
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  in_idx;
    logic [KNOT_W-1:0] in_val;
    logic [POS_W-1:0]  in_pos;
    logic              in_take;

    assign in_idx  = s_tdata[IDX_LSB +: IDX_W];
    assign in_val  = s_tdata[VAL_LSB +: KNOT_W];
    assign in_pos  = s_tdata[POS_LSB +: POS_W];
    assign in_take = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Span and fraction, formed as the evaluate word is taken
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  n_m3;
    logic [T_W-1:0]    t_pos;
    logic [SPAN_W-1:0] span_raw;
    logic [SPAN_W-1:0] span_calc;
    logic [T_W-1:0]    c1_calc;

    always_comb
    begin
        // clamp knot count into [4, MAX_KNOTS]
        if (knot_count_reg < CNT_W'(4))
        begin
            n_eff = CNT_W'(4);
        end
        else if (32'(knot_count_reg) > MAX_KNOTS)
        begin
            n_eff = CNT_W'(MAX_KNOTS);
        end
        else
        begin
            n_eff = knot_count_reg;
        end
        n_m3     = n_eff - CNT_W'(3);
        t_pos    = T_W'(in_pos) * T_W'(n_m3);
        span_raw = t_pos[FRAC_SHIFT +: SPAN_W];
        // beyond the curve end: stay in the last span and extrapolate
        if (span_raw >= SPAN_W'(n_m3))
        begin
            span_calc = SPAN_W'(n_eff - CNT_W'(4));
        end
        else
        begin
            span_calc = span_raw;
        end
        c1_calc = t_pos - (T_W'(span_calc) << FRAC_SHIFT);
    end

    // ------------------------------------------------------------------
    // Knot memory. Writes happen only in idle, reads only in the read
    // phase, so the two never touch the same cycle.
    // ------------------------------------------------------------------
    logic              mem_we;
    logic [AW-1:0]     mem_wr_addr;
    logic              mem_re;
    logic [AW-1:0]     mem_rd_addr;
    logic [KNOT_W-1:0] mem_rd_data;

    // drop writes to slots beyond the table
    assign mem_we      = in_take && (s_tuser == KIND_WRITE) && (32'(in_idx) < MAX_KNOTS);
    assign mem_wr_addr = AW'(in_idx);
    assign mem_re      = (state_reg == ST_READ);
    assign mem_rd_addr = AW'(span_reg + SPAN_W'(rd_cnt_reg));

    crse_knot_mem #(
        .DEPTH  (MAX_KNOTS),
        .ADDR_W (AW)
    ) u_knot_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (in_val),
        .re      (mem_re),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // Horner datapath
    // ------------------------------------------------------------------
    crse_hctl_t        hctl;
    logic [KNOT_W-1:0] acc;

    always_comb
    begin
        // read data is registered, so it arrives in the cycle after its address
        hctl.cap_en  = (state_reg == ST_READ) && (rd_cnt_reg != 2'd0);
        hctl.cap_sel = rd_cnt_reg - 2'd1;
        hctl.prep    = (state_reg == ST_PREP);
        hctl.mul     = (state_reg == ST_MUL);
        hctl.add     = (state_reg == ST_ADD);
        hctl.step    = step_reg;
    end

    crse_horner u_horner (
        .clk     (clk),
        .ctl     (hctl),
        .c1      (c1_reg),
        .rd_data (mem_rd_data),
        .acc     (acc)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        step_next      = step_reg;
        span_next      = span_reg;
        c1_next        = c1_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        // free the output register once the word is taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (s_tuser == KIND_EVAL))
                begin
                    span_next   = span_calc;
                    c1_next     = c1_calc;
                    rd_cnt_next = 2'd0;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                // issue knots span .. span+3
                rd_cnt_next = rd_cnt_reg + 2'd1;
                if (rd_cnt_reg == 2'd3)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                step_next  = STEP_B;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (step_reg == STEP_END)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next  = step_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = acc;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= 2'd0;
            step_reg      <= STEP_B;
            out_valid_reg <= 1'b0;
            span_reg      <= '0;
            c1_reg        <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            span_reg      <= span_next;
            c1_reg        <= c1_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[APB_ADDR_W-1] == REG_KNOT_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knot_count_reg <= KNOT_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            knot_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[APB_ADDR_W-1] == REG_KNOT_COUNT)
        begin
            prdata = APB_DATA_W'(knot_count_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_eval_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == KIND_EVAL)) |=> (state_reg == ST_READ))
        else $error("evaluate word did not start the knot reads");

    a_prep_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |-> ($past(state_reg) == ST_READ && $past(rd_cnt_reg) == 2'd3))
        else $error("prep entered before all four knots were read");

    a_span_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> ((32'(span_reg) + 3) < MAX_KNOTS))
        else $error("span reaches past the knot table");

    a_no_mem_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("knot write overlaps a read");

endmodule : catmull_rom_spline_eval
`default_nettype wire
